// File: src/cbr_pkg.sv
// shared types and constants for the column bottom-row edge finder
`default_nettype none
package cbr_pkg;

   localparam int COL_W   = 12;
   localparam int ROW_W   = 12;
   localparam int CHAN_W  = 8;
   localparam int LEVEL_W = 8;
   localparam int CSR_IDX_W = 8;

   // luminance weights, sum is taken to 22 bits and shifted down by 14
   localparam int SUM_W   = 22;
   localparam int SHIFT   = 14;
   localparam logic [13:0] COEF_R = 14'd4915;
   localparam logic [13:0] COEF_G = 14'd9667;
   localparam logic [13:0] COEF_B = 14'd1802;
   localparam logic [SUM_W-1:0] ROUND = 22'd8192;

   localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd24;
   localparam logic [CHAN_W-1:0] MAGENTA_RESET   = 8'd240;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHT_THRESHOLD = 8'd0,
      CSR_MAGENTA_LEVEL    = 8'd1
   } csr_index_type;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_READ  = 1'b1
   } action_type;

   typedef struct packed {
      action_type       action;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             in_range;
   } item_type;

   typedef struct packed {
      logic wr_en;
      logic wr_found;
      logic rd_en;
   } mem_ctl_type;

endpackage
`default_nettype wire

// File: src/cbr_level.sv
// pixel level pipeline stage: registered luminance products and magenta select
`default_nettype none
module cbr_level
   import cbr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [CHAN_W-1:0]  red,
   input  wire logic [CHAN_W-1:0]  green,
   input  wire logic [CHAN_W-1:0]  blue,
   input  wire logic [CHAN_W-1:0]  magenta_level,
   output logic [LEVEL_W-1:0]      level
);

   logic [SUM_W-1:0]  prod_r_ff, prod_r_in;
   logic [SUM_W-1:0]  prod_g_ff, prod_g_in;
   logic [SUM_W-1:0]  prod_b_ff, prod_b_in;
   logic [CHAN_W-1:0] green_ff;
   logic              mag_sel_ff, mag_sel_in;
   logic [SUM_W-1:0]  sum;

   always_comb begin
      prod_r_in  = SUM_W'(red)   * SUM_W'(COEF_R);
      prod_g_in  = SUM_W'(green) * SUM_W'(COEF_G);
      prod_b_in  = SUM_W'(blue)  * SUM_W'(COEF_B);
      mag_sel_in = (red >= magenta_level) && (blue >= magenta_level);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_r_ff  <= prod_r_in;
         prod_g_ff  <= prod_g_in;
         prod_b_ff  <= prod_b_in;
         green_ff   <= green;
         mag_sel_ff <= mag_sel_in;
      end
   end

   always_comb begin
      sum   = prod_r_ff + prod_g_ff + prod_b_ff + ROUND;
      level = mag_sel_ff ? green_ff : sum[SUM_W-1:SHIFT];
   end

endmodule
`default_nettype wire

// File: src/cbr_column_mem.sv
// per-column record memory: found flag and bottom row, one write and one registered read
`default_nettype none
module cbr_column_mem
   import cbr_pkg::*;
#(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
)(
   input  wire logic              clock,
   input  wire mem_ctl_type       ctl,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [ROW_W-1:0]  wr_row,
   output logic                   rd_found,
   output logic [ROW_W-1:0]       rd_row
);

   logic [ROW_W:0] mem [DEPTH];
   logic [ROW_W:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= {ctl.wr_found, wr_row};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_found = rd_data_ff[ROW_W];
   assign rd_row   = rd_data_ff[ROW_W-1:0];

endmodule
`default_nettype wire

// File: src/column_bottom_row_edge_finder_core.sv
// top level of the column bottom-row edge finder
`default_nettype none
// Takes one word per clock unless stalled, pixels in raster order or column reads, and returns
// one word for each from its output register. A pixel word gives its level (green when red and blue
// reach magenta_level, else rounded luminance) a compare against bright_threshold and reports
// whether it is the first hit of its row. Per column a record of found flag and lowest hit row
// lives in one memory of MAX_WIDTH entries (at most 4096): a pixel in row 0 overwrites it, a
// hit in a later row updates it, a read word returns it. The memory has one access per word,
// so the rate is one word per cycle unless stalled, for any mix of pixels and reads. Records
// are not cleared at reset; read a column only after a frame has written it. Pixels outside
// MAX_WIDTH or MAX_HEIGHT change nothing and reads outside MAX_WIDTH answer zero. Stalls on the
// result side hold the whole pipeline.
module column_bottom_row_edge_finder_core
   import cbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [47:0]          req_tdata,   // column, row, red, green, blue
   input  wire logic                 req_tuser,   // action
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,   // row_first_hit, column_found, column_bottom_row, zero pad
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CHAN_W-1:0]    csr_data
);

   localparam int MEM_DEPTH = (MAX_WIDTH < (1 << COL_W)) ? MAX_WIDTH : (1 << COL_W);
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   logic [CHAN_W-1:0] threshold_ff, threshold_in;
   logic [CHAN_W-1:0] magenta_ff, magenta_in;

   logic              en;
   item_type          item_in;
   item_type          s1_item_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [LEVEL_W-1:0] level;
   logic              hit;
   logic              seen_base;
   logic              pixel_ok;
   logic              first_hit_in;
   logic              row_hit_seen_ff, row_hit_seen_in;
   mem_ctl_type       mem_ctl;
   logic              rd_found;
   logic [ROW_W-1:0]  rd_row;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              first_hit_ff;
   logic              rd_sel_ff;

   // config
   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      magenta_in   = magenta_ff;
      if (csr_valid) begin
         if (csr_index == CSR_BRIGHT_THRESHOLD) begin
            threshold_in = csr_data;
         end
         if (csr_index == CSR_MAGENTA_LEVEL) begin
            magenta_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         magenta_ff   <= MAGENTA_RESET;
      end else begin
         threshold_ff <= threshold_in;
         magenta_ff   <= magenta_in;
      end
   end

   // input stage
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      item_in.action   = action_type'(req_tuser);
      item_in.column   = req_tdata[11:0];
      item_in.row      = req_tdata[23:12];
      item_in.in_range = ({20'd0, req_tdata[11:0]} < 32'(MAX_WIDTH)) &&
                         ((req_tuser == ACTION_READ) ||
                          ({20'd0, req_tdata[23:12]} < 32'(MAX_HEIGHT)));
      s1_valid_in      = req_tvalid;
   end

   cbr_level u_level (
      .clock         (clock),
      .en            (en),
      .red           (req_tdata[31:24]),
      .green         (req_tdata[39:32]),
      .blue          (req_tdata[47:40]),
      .magenta_level (magenta_ff),
      .level         (level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= item_in;
      end
   end

   // hit decision and memory access
   always_comb begin
      hit          = level > threshold_ff;
      pixel_ok     = en && s1_valid_ff && (s1_item_ff.action == ACTION_PIXEL) &&
                     s1_item_ff.in_range;
      seen_base    = (s1_item_ff.column == '0) ? 1'b0 : row_hit_seen_ff;
      first_hit_in = pixel_ok && hit && !seen_base;
      row_hit_seen_in = row_hit_seen_ff;
      if (pixel_ok) begin
         row_hit_seen_in = seen_base || hit;
      end
      mem_ctl.wr_en    = pixel_ok && ((s1_item_ff.row == '0) || hit);
      mem_ctl.wr_found = hit;
      mem_ctl.rd_en    = en && s1_valid_ff && (s1_item_ff.action == ACTION_READ) &&
                         s1_item_ff.in_range;
   end

   cbr_column_mem #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_column_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .addr     (s1_item_ff.column[ADDR_W-1:0]),
      .wr_row   (s1_item_ff.row),
      .rd_found (rd_found),
      .rd_row   (rd_row)
   );

   // output register
   assign rsp_valid_in = en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         row_hit_seen_ff <= 1'b0;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         row_hit_seen_ff <= row_hit_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         first_hit_ff <= first_hit_in;
         rd_sel_ff    <= mem_ctl.rd_en;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rd_sel_ff ? rd_row : {ROW_W{1'b0}},
                        rd_sel_ff && rd_found,
                        first_hit_ff};

`ifndef SYNTH
   a_no_write_and_read: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("column memory written and read for one word");

   a_first_hit_sets_seen: assert property (@(posedge clock) disable iff (reset)
      first_hit_in |=> row_hit_seen_ff)
      else $error("first hit of a row did not mark the row");

   a_flag_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(first_hit_ff && rd_sel_ff))
      else $error("result word carries both pixel and read data");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      (en && s1_valid_ff) |=> rsp_valid_ff)
      else $error("word lost between pipeline stages");
`endif

endmodule
`default_nettype wire

// File: sim/tb.sv
// testbench for the column bottom-row edge finder: random raster frames, reads and checks
`default_nettype none
module tb;
   import cbr_pkg::*;

   typedef struct packed {
      logic             first_hit;
      logic             found;
      logic [ROW_W-1:0] bottom;
   } edge_word_type;

   class edge_tracker;
      logic [LEVEL_W-1:0] threshold;
      logic [LEVEL_W-1:0] magenta;
      logic [ROW_W-1:0]   lowest_hit_row [0:4095];
      bit                 column_hit [0:4095];
      bit                 row_has_hit;
      edge_word_type      pending_words [$];
      int                 errors;

      function new();
         threshold   = THRESHOLD_RESET;
         magenta     = MAGENTA_RESET;
         row_has_hit = 1'b0;
         errors      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CHAN_W-1:0] value);
         case (idx)
            CSR_BRIGHT_THRESHOLD: threshold = value;
            CSR_MAGENTA_LEVEL:    magenta = value;
            default: ;
         endcase
      endfunction

      function bit is_hit(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
         int unsigned lum;
         if (r >= magenta && b >= magenta)
            lum = g;
         else
            lum = (4915 * int'(r) + 9667 * int'(g) + 1802 * int'(b) + 8192) >> 14;
         return lum > threshold;
      endfunction

      function void note_word(action_type act, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                              logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b);
         edge_word_type w;
         bit hit;
         w = '0;
         if (act == ACTION_READ) begin
            w.found  = column_hit[col];
            w.bottom = lowest_hit_row[col];
         end else begin
            if (col == 0) row_has_hit = 1'b0;
            hit = is_hit(r, g, b);
            w.first_hit = hit && !row_has_hit;
            if (hit) row_has_hit = 1'b1;
            if (row == 0) begin
               column_hit[col]     = hit;
               lowest_hit_row[col] = '0;
            end else if (hit) begin
               column_hit[col]     = 1'b1;
               lowest_hit_row[col] = row;
            end
         end
         pending_words.push_back(w);
      endfunction

      task report(string msg);
         if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_word(logic [15:0] data);
         edge_word_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("word %h arrived with nothing pending", data));
            return;
         end
         want = pending_words.pop_front();
         if (data[0] !== want.first_hit)
            report($sformatf("row_first_hit %b, wanted %b", data[0], want.first_hit));
         if (data[1] !== want.found)
            report($sformatf("column_found %b, wanted %b", data[1], want.found));
         if (data[13:2] !== want.bottom)
            report($sformatf("column_bottom_row %0d, wanted %0d", data[13:2], want.bottom));
      endtask

      task finish_check();
         if (pending_words.size() != 0)
            report($sformatf("%0d words never arrived", pending_words.size()));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;   // column, row, red, green, blue
   logic                 req_tuser;   // action
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;   // row_first_hit, column_found, column_bottom_row, zero pad
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CHAN_W-1:0]    csr_data;

   edge_tracker tracker = new();
   int          idle_cycles = 0;
   int          sent_words = 0;
   int          burst_left = 0;
   bit          steady_feed = 1'b0;
   bit          hold_req = 1'b0;
   bit          col_written [0:4095];
   int          known_cols [$];

   column_bottom_row_edge_finder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_word(action_type'(req_tuser), req_tdata[11:0], req_tdata[23:12],
                              req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_word(rsp_tdata);
         if (csr_valid && csr_ready)
            tracker.set_reg(csr_index_type'(csr_index), csr_data);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < 4000) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : receiver
      int mode;
      int left;
      int hold;
      rsp_tready = 1'b0;
      mode = 0;
      left = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold = 400;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(30, 150);
         end else begin
            left--;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= left[2];
            endcase
         end
      end
   end

   task automatic send_word(action_type act, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
      int gap;
      req_tuser  <= act;
      req_tdata  <= {b, g, r, row, col};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_words++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 15);
         if (!steady_feed) begin
            gap = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic put_pixel(int col, int row, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                            logic [CHAN_W-1:0] b);
      if ((row % 4096 == 0 || tracker.is_hit(r, g, b)) && !col_written[col % 4096]) begin
         col_written[col % 4096] = 1'b1;
         known_cols.push_back(col % 4096);
      end
      send_word(ACTION_PIXEL, COL_W'(col), ROW_W'(row), r, g, b);
   endtask

   task automatic put_read(int col);
      send_word(ACTION_READ, COL_W'(col), ROW_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom), CHAN_W'($urandom));
   endtask

   task automatic read_known();
      if (known_cols.size() > 0)
         put_read(known_cols[$urandom_range(0, known_cols.size() - 1)]);
   endtask

   task automatic pick_color(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                             output logic [CHAN_W-1:0] b);
      int v;
      case ($urandom_range(0, 4))
         0: begin
            r = CHAN_W'($urandom); g = CHAN_W'($urandom); b = CHAN_W'($urandom);
         end
         1: begin
            r = CHAN_W'($urandom_range(0, 40)); g = CHAN_W'($urandom_range(0, 40));
            b = CHAN_W'($urandom_range(0, 40));
         end
         2: begin
            r = CHAN_W'($urandom_range(tracker.magenta, 255));
            b = CHAN_W'($urandom_range(tracker.magenta, 255));
            g = CHAN_W'($urandom);
         end
         3: begin
            r = CHAN_W'($urandom_range(180, 255)); g = CHAN_W'($urandom_range(180, 255));
            b = CHAN_W'($urandom_range(180, 255));
         end
         default: begin
            // gray around the threshold, luminance of gray equals its value
            v = int'(tracker.threshold) + $urandom_range(0, 2) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r = CHAN_W'(v); g = CHAN_W'(v); b = CHAN_W'(v);
         end
      endcase
   endtask

   task automatic run_frame();
      int w;
      int h;
      int stride;
      int x;
      int y;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      if ($urandom_range(0, 39) == 0) begin
         w = $urandom_range(64, 160);
         h = 1;
      end else begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 12);
      end
      stride = 1;
      if (h > 1 && $urandom_range(0, 3) == 0)
         stride = $urandom_range(1, 4095 / (h - 1));
      for (y = 0; y < h; y++) begin
         for (x = 0; x < w; x++) begin
            pick_color(r, g, b);
            put_pixel(x, y * stride, r, g, b);
            if ($urandom_range(0, 19) == 0) read_known();
         end
      end
      repeat ($urandom_range(1, (w < 8) ? w : 8)) put_read($urandom_range(0, w - 1));
   endtask

   task automatic random_phase(int count);
      int start;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      start = sent_words;
      while (sent_words - start < count) begin
         case ($urandom_range(0, 9))
            7, 8: begin
               repeat ($urandom_range(1, 4)) begin
                  pick_color(r, g, b);
                  put_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), r, g, b);
               end
            end
            9: repeat ($urandom_range(1, 4)) read_known();
            default: run_frame();
         endcase
      end
   endtask

   task drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_words.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(csr_index_type idx, logic [CHAN_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task directed();
      put_pixel(0, 0, 8'd0, 8'd0, 8'd0);
      put_pixel(1, 0, 8'd255, 8'd255, 8'd255);
      put_pixel(2, 0, 8'd255, 8'd0, 8'd255);        // magenta, green too dark
      put_pixel(3, 0, 8'd240, 8'd30, 8'd240);       // magenta right at the level
      put_pixel(4, 0, 8'd239, 8'd0, 8'd239);        // just below magenta, luminance
      put_pixel(4095, 0, 8'd0, 8'd0, 8'd0);
      put_read(1);
      put_read(0);
      put_pixel(0, 1, 8'd0, 8'd40, 8'd0);           // level equal to threshold
      put_pixel(1, 1, 8'd0, 8'd42, 8'd0);           // one above, first hit of row
      put_pixel(2, 1, 8'd255, 8'd255, 8'd0);
      put_pixel(0, 4095, 8'd255, 8'd255, 8'd255);
      put_pixel(4095, 4095, 8'd255, 8'd255, 8'd255);
      put_pixel(3, 4095, 8'd0, 8'd0, 8'd0);         // miss keeps the record
      send_word(ACTION_READ, 12'd0, 12'hfff, 8'hff, 8'hff, 8'hff);
      put_read(2);
      put_read(3);
      put_read(4095);
      put_read(4);
      put_pixel(0, 0, 8'd10, 8'd10, 8'd10);         // row 0 overwrites the column
      put_read(0);
   endtask

   initial begin : stimulus
      int p;
      logic [CHAN_W-1:0] thr_set [0:6];
      logic [CHAN_W-1:0] mag_set [0:6];
      thr_set = '{8'd24, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd24};
      mag_set = '{8'd240, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd240};
      thr_set[5] = CHAN_W'($urandom);
      mag_set[5] = CHAN_W'($urandom);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACTION_PIXEL;
      csr_valid  = 1'b0;
      csr_index  = CSR_BRIGHT_THRESHOLD;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      drain();
      for (p = 0; p < 7; p++) begin
         if (p > 0) begin
            write_reg(CSR_BRIGHT_THRESHOLD, thr_set[p]);
            write_reg(CSR_MAGENTA_LEVEL, mag_set[p]);
         end
         if (p == 3) begin
            // receiver holds off while the sender keeps the input busy
            hold_req = 1'b1;
            steady_feed = 1'b1;
            random_phase(80);
            steady_feed = 1'b0;
         end
         random_phase(125);
         drain();
      end
      repeat (10) @(posedge clock);
      tracker.finish_check();
      if (tracker.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
